>>> rtl/ebdalu_pkg.sv
// Package for the extended block and digit ALU.
// Holds the operation codes, flag bit positions and the result record.
// Used by ebdalu_core and ext_block_and_digit_alu_top.
package ebdalu_pkg;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned FLAG_W = 6;

	localparam int unsigned FLAG_S  = 5;
	localparam int unsigned FLAG_Z  = 4;
	localparam int unsigned FLAG_H  = 3;
	localparam int unsigned FLAG_PV = 2;
	localparam int unsigned FLAG_N  = 1;
	localparam int unsigned FLAG_C  = 0;

	typedef enum logic [OP_W-1:0] {
		OP_NEG = 3'd0,
		OP_RRD = 3'd1,
		OP_RLD = 3'd2,
		OP_LDI = 3'd3,
		OP_LDD = 3'd4,
		OP_CPI = 3'd5,
		OP_CPD = 3'd6
	} op_t;

	typedef struct packed {
		logic [BYTE_W-1:0] a_out;
		logic [FLAG_W-1:0] flags_out;
		logic [WORD_W-1:0] bc_out;
		logic [WORD_W-1:0] de_out;
		logic [WORD_W-1:0] hl_out;
		logic              mem_write;
		logic [WORD_W-1:0] mem_addr;
		logic [BYTE_W-1:0] mem_data;
		logic              repeat_again;
	} ebdalu_res_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [BYTE_W-1:0] reg_a;
		logic [FLAG_W-1:0] flags_in;
		logic [WORD_W-1:0] reg_bc;
		logic [WORD_W-1:0] reg_de;
		logic [WORD_W-1:0] reg_hl;
		logic [BYTE_W-1:0] mem_byte;
	} ebdalu_req_t;

	function automatic logic even_parity(input logic [BYTE_W-1:0] v);
		return ~(^v);
	endfunction

endpackage

>>> rtl/ebdalu_core.sv
// Combinational execute logic of the extended block and digit ALU.
// Maps one registered request to its result record.
// Depends on ebdalu_pkg.
module ebdalu_core (
	input  ebdalu_pkg::ebdalu_req_t req,
	output ebdalu_pkg::ebdalu_res_t res
);
	import ebdalu_pkg::*;

	logic [BYTE_W-1:0] neg_r;
	logic [BYTE_W-1:0] diff;
	logic [BYTE_W-1:0] rot_a;
	logic [BYTE_W-1:0] rot_m;
	logic [WORD_W-1:0] bc_dec;
	logic              bc_nz;

	assign neg_r  = BYTE_W'(0) - req.reg_a;
	assign diff   = req.reg_a - req.mem_byte;
	assign bc_dec = req.reg_bc - WORD_W'(1);
	assign bc_nz  = (bc_dec != '0);

	always_comb begin
		res              = '0;
		res.a_out        = req.reg_a;
		res.flags_out    = req.flags_in;
		res.bc_out       = req.reg_bc;
		res.de_out       = req.reg_de;
		res.hl_out       = req.reg_hl;
		rot_a            = {req.reg_a[7:4], req.mem_byte[3:0]};
		rot_m            = {req.reg_a[3:0], req.mem_byte[7:4]};
		unique case (op_t'(req.operation))
			OP_NEG: begin
				res.a_out             = neg_r;
				res.flags_out         = '0;
				res.flags_out[FLAG_S]  = neg_r[7];
				res.flags_out[FLAG_Z]  = (neg_r == '0);
				res.flags_out[FLAG_H]  = (req.reg_a[3:0] != '0);
				res.flags_out[FLAG_PV] = (req.reg_a == 8'h80);
				res.flags_out[FLAG_N]  = 1'b1;
				res.flags_out[FLAG_C]  = (req.reg_a != '0);
			end
			OP_RRD, OP_RLD: begin
				if (op_t'(req.operation) == OP_RLD) begin
					rot_a = {req.reg_a[7:4], req.mem_byte[7:4]};
					rot_m = {req.mem_byte[3:0], req.reg_a[3:0]};
				end
				res.a_out              = rot_a;
				res.flags_out          = '0;
				res.flags_out[FLAG_S]  = rot_a[7];
				res.flags_out[FLAG_Z]  = (rot_a == '0);
				res.flags_out[FLAG_PV] = even_parity(rot_a);
				res.flags_out[FLAG_C]  = req.flags_in[FLAG_C];
				res.mem_write          = 1'b1;
				res.mem_addr           = req.reg_hl;
				res.mem_data           = rot_m;
			end
			OP_LDI, OP_LDD: begin
				if (op_t'(req.operation) == OP_LDI) begin
					res.hl_out = req.reg_hl + WORD_W'(1);
					res.de_out = req.reg_de + WORD_W'(1);
				end else begin
					res.hl_out = req.reg_hl - WORD_W'(1);
					res.de_out = req.reg_de - WORD_W'(1);
				end
				res.bc_out             = bc_dec;
				res.flags_out[FLAG_H]  = 1'b0;
				res.flags_out[FLAG_N]  = 1'b0;
				res.flags_out[FLAG_PV] = bc_nz;
				res.mem_write          = 1'b1;
				res.mem_addr           = req.reg_de;
				res.mem_data           = req.mem_byte;
				res.repeat_again       = bc_nz;
			end
			OP_CPI, OP_CPD: begin
				if (op_t'(req.operation) == OP_CPI) begin
					res.hl_out = req.reg_hl + WORD_W'(1);
				end else begin
					res.hl_out = req.reg_hl - WORD_W'(1);
				end
				res.bc_out             = bc_dec;
				res.flags_out[FLAG_S]  = diff[7];
				res.flags_out[FLAG_Z]  = (diff == '0);
				res.flags_out[FLAG_H]  = (req.reg_a[3:0] < req.mem_byte[3:0]);
				res.flags_out[FLAG_PV] = bc_nz;
				res.flags_out[FLAG_N]  = 1'b1;
				res.repeat_again       = bc_nz && (diff != '0);
			end
			default: begin
				res.mem_write = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/ext_block_and_digit_alu_top.sv
// Top level of the extended block and digit ALU: input register, execute logic
// and result register with valid/stall handshakes on both sides.
// Depends on ebdalu_pkg and ebdalu_core.
//
//   channel | valid     | stall     | payload
//   req     | req_valid | req_stall | operation, reg_a, flags_in, reg_bc, reg_de, reg_hl, mem_byte
//   rsp     | rsp_valid | rsp_stall | a_out, flags_out, bc_out, de_out, hl_out, mem_*, repeat_again
//
// Each item is captured in the input register, passes through the execute logic and is
// captured in the result register, from which its result is offered; one item is taken
// every cycle while the input side does not stall.
// Reset empties both stages. A stalled result holds; the input side stalls only when
// both stages are full and the result is stalled.
module ext_block_and_digit_alu_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [ebdalu_pkg::OP_W-1:0]     operation,
	input  logic [ebdalu_pkg::BYTE_W-1:0]   reg_a,
	input  logic [ebdalu_pkg::FLAG_W-1:0]   flags_in,
	input  logic [ebdalu_pkg::WORD_W-1:0]   reg_bc,
	input  logic [ebdalu_pkg::WORD_W-1:0]   reg_de,
	input  logic [ebdalu_pkg::WORD_W-1:0]   reg_hl,
	input  logic [ebdalu_pkg::BYTE_W-1:0]   mem_byte,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [ebdalu_pkg::BYTE_W-1:0]   a_out,
	output logic [ebdalu_pkg::FLAG_W-1:0]   flags_out,
	output logic [ebdalu_pkg::WORD_W-1:0]   bc_out,
	output logic [ebdalu_pkg::WORD_W-1:0]   de_out,
	output logic [ebdalu_pkg::WORD_W-1:0]   hl_out,
	output logic                            mem_write,
	output logic [ebdalu_pkg::WORD_W-1:0]   mem_addr,
	output logic [ebdalu_pkg::BYTE_W-1:0]   mem_data,
	output logic                            repeat_again
);
	import ebdalu_pkg::*;

	ebdalu_req_t req_s1;
	ebdalu_res_t res_c;
	ebdalu_res_t res_s2;
	logic        vld_s1;
	logic        vld_s2;
	logic        adv_s1;
	logic        adv_s2;

	assign adv_s2    = !vld_s2 || !rsp_stall;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign req_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= req_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= '{operation: operation, reg_a: reg_a, flags_in: flags_in,
				reg_bc: reg_bc, reg_de: reg_de, reg_hl: reg_hl, mem_byte: mem_byte};
		end
		if (adv_s2 && vld_s1) begin
			res_s2 <= res_c;
		end
	end

	ebdalu_core u_core (
		.req (req_s1),
		.res (res_c)
	);

	assign rsp_valid    = vld_s2;
	assign a_out        = res_s2.a_out;
	assign flags_out    = res_s2.flags_out;
	assign bc_out       = res_s2.bc_out;
	assign de_out       = res_s2.de_out;
	assign hl_out       = res_s2.hl_out;
	assign mem_write    = res_s2.mem_write;
	assign mem_addr     = res_s2.mem_addr;
	assign mem_data     = res_s2.mem_data;
	assign repeat_again = res_s2.repeat_again;

`ifndef SYNTHESIS
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (vld_s1 && vld_s2))
		else $error("input stalled while a stage is free");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !vld_s2) |=> rsp_valid)
		else $error("item in input register did not reach the result register");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !mem_write) |-> (mem_addr == '0 && mem_data == '0))
		else $error("write address or data set without a write");

	a_repeat_bc: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && repeat_again) |-> (bc_out != '0 && flags_out[FLAG_PV]))
		else $error("repeat requested with a zero counter");
`endif

endmodule

>>> sim/tb.sv
// Self-checking testbench for ext_block_and_digit_alu_top: a queue-fed driver with its own
// predictor of every operation, a result monitor, and a watchdog on stalled progress.
// Depends on ebdalu_pkg and the RTL of ext_block_and_digit_alu_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ebdalu_pkg::*;

	localparam logic [OP_W-1:0] OP_NOP = 3'd7;
	localparam int HOLD_AT = 150;
	localparam int HOLD_LEN = 64;
	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 440;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [OP_W-1:0] operation = '0;
	logic [BYTE_W-1:0] reg_a = '0;
	logic [FLAG_W-1:0] flags_in = '0;
	logic [WORD_W-1:0] reg_bc = '0;
	logic [WORD_W-1:0] reg_de = '0;
	logic [WORD_W-1:0] reg_hl = '0;
	logic [BYTE_W-1:0] mem_byte = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [BYTE_W-1:0] a_out;
	logic [FLAG_W-1:0] flags_out;
	logic [WORD_W-1:0] bc_out;
	logic [WORD_W-1:0] de_out;
	logic [WORD_W-1:0] hl_out;
	logic mem_write;
	logic [WORD_W-1:0] mem_addr;
	logic [BYTE_W-1:0] mem_data;
	logic repeat_again;

	ebdalu_req_t pending_items[$];
	ebdalu_res_t expected_results[$];
	ebdalu_res_t want;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int results_seen = 0;
	int items_sent = 0;
	int holdoff_left = 0;
	int idle_cycles = 0;
	bit held_off = 1'b0;

	ext_block_and_digit_alu_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .reg_a(reg_a), .flags_in(flags_in),
		.reg_bc(reg_bc), .reg_de(reg_de), .reg_hl(reg_hl), .mem_byte(mem_byte),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.a_out(a_out), .flags_out(flags_out), .bc_out(bc_out), .de_out(de_out),
		.hl_out(hl_out), .mem_write(mem_write), .mem_addr(mem_addr),
		.mem_data(mem_data), .repeat_again(repeat_again)
	);

	function automatic ebdalu_res_t compute_result(input ebdalu_req_t q);
		ebdalu_res_t r;
		logic [FLAG_W-1:0] f;
		logic [BYTE_W-1:0] na;
		logic [BYTE_W-1:0] diff;
		r = '0;
		r.a_out = q.reg_a;
		r.flags_out = q.flags_in;
		r.bc_out = q.reg_bc;
		r.de_out = q.reg_de;
		r.hl_out = q.reg_hl;
		f = q.flags_in;
		case (q.operation)
			OP_NEG: begin
				na = 8'd0 - q.reg_a;
				f = '0;
				f[FLAG_S] = na[7];
				f[FLAG_Z] = (na == 8'd0);
				f[FLAG_H] = (q.reg_a[3:0] != 4'd0);
				f[FLAG_PV] = (q.reg_a == 8'h80);
				f[FLAG_N] = 1'b1;
				f[FLAG_C] = (q.reg_a != 8'd0);
				r.a_out = na;
				r.flags_out = f;
			end
			OP_RRD, OP_RLD: begin
				if (q.operation == OP_RRD) begin
					na = {q.reg_a[7:4], q.mem_byte[3:0]};
					r.mem_data = {q.reg_a[3:0], q.mem_byte[7:4]};
				end else begin
					na = {q.reg_a[7:4], q.mem_byte[7:4]};
					r.mem_data = {q.mem_byte[3:0], q.reg_a[3:0]};
				end
				f = '0;
				f[FLAG_C] = q.flags_in[FLAG_C];
				f[FLAG_S] = na[7];
				f[FLAG_Z] = (na == 8'd0);
				f[FLAG_PV] = ~(^na);
				r.a_out = na;
				r.flags_out = f;
				r.mem_write = 1'b1;
				r.mem_addr = q.reg_hl;
			end
			OP_LDI, OP_LDD: begin
				r.mem_write = 1'b1;
				r.mem_addr = q.reg_de;
				r.mem_data = q.mem_byte;
				if (q.operation == OP_LDI) begin
					r.hl_out = q.reg_hl + 16'd1;
					r.de_out = q.reg_de + 16'd1;
				end else begin
					r.hl_out = q.reg_hl - 16'd1;
					r.de_out = q.reg_de - 16'd1;
				end
				r.bc_out = q.reg_bc - 16'd1;
				f[FLAG_H] = 1'b0;
				f[FLAG_N] = 1'b0;
				f[FLAG_PV] = (r.bc_out != 16'd0);
				r.flags_out = f;
				r.repeat_again = (r.bc_out != 16'd0);
			end
			OP_CPI, OP_CPD: begin
				diff = q.reg_a - q.mem_byte;
				if (q.operation == OP_CPI)
					r.hl_out = q.reg_hl + 16'd1;
				else
					r.hl_out = q.reg_hl - 16'd1;
				r.bc_out = q.reg_bc - 16'd1;
				f = '0;
				f[FLAG_C] = q.flags_in[FLAG_C];
				f[FLAG_N] = 1'b1;
				f[FLAG_S] = diff[7];
				f[FLAG_Z] = (diff == 8'd0);
				f[FLAG_H] = (q.reg_a[3:0] < q.mem_byte[3:0]);
				f[FLAG_PV] = (r.bc_out != 16'd0);
				r.flags_out = f;
				r.repeat_again = (r.bc_out != 16'd0) && (diff != 8'd0);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic ebdalu_req_t make_item(input logic [OP_W-1:0] op,
			input logic [BYTE_W-1:0] a, input logic [FLAG_W-1:0] f,
			input logic [WORD_W-1:0] bc, input logic [WORD_W-1:0] de,
			input logic [WORD_W-1:0] hl, input logic [BYTE_W-1:0] m);
		ebdalu_req_t q;
		q.operation = op;
		q.reg_a = a;
		q.flags_in = f;
		q.reg_bc = bc;
		q.reg_de = de;
		q.reg_hl = hl;
		q.mem_byte = m;
		return q;
	endfunction

	function automatic ebdalu_req_t random_item();
		ebdalu_req_t q;
		q = make_item(OP_W'($urandom_range(7)), BYTE_W'($urandom), FLAG_W'($urandom),
			WORD_W'($urandom), WORD_W'($urandom), WORD_W'($urandom), BYTE_W'($urandom));
		case ($urandom_range(7))
			0: q.reg_bc = WORD_W'($urandom_range(2));
			1: q.mem_byte = q.reg_a;
			2: q.reg_a = $urandom_range(1) ? 8'h80 : 8'h00;
			3: begin
				q.reg_hl = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				q.reg_de = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			end
			4: begin
				q.reg_bc = 16'd1;
				q.mem_byte = q.reg_a;
			end
			default: begin
			end
		endcase
		return q;
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
			input logic [WORD_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) begin
				expected_results.push_back(compute_result(make_item(operation, reg_a,
					flags_in, reg_bc, reg_de, reg_hl, mem_byte)));
				items_sent++;
			end
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				ebdalu_req_t nxt;
				nxt = pending_items.pop_front();
				operation <= nxt.operation;
				reg_a <= nxt.reg_a;
				flags_in <= nxt.flags_in;
				reg_bc <= nxt.reg_bc;
				reg_de <= nxt.reg_de;
				reg_hl <= nxt.reg_hl;
				mem_byte <= nxt.mem_byte;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$error("result arrived with no item outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("a_out", WORD_W'(want.a_out), WORD_W'(a_out));
					check_field("flags_out", WORD_W'(want.flags_out), WORD_W'(flags_out));
					check_field("bc_out", want.bc_out, bc_out);
					check_field("de_out", want.de_out, de_out);
					check_field("hl_out", want.hl_out, hl_out);
					check_field("mem_write", WORD_W'(want.mem_write), WORD_W'(mem_write));
					check_field("mem_addr", want.mem_addr, mem_addr);
					check_field("mem_data", WORD_W'(want.mem_data), WORD_W'(mem_data));
					check_field("repeat_again", WORD_W'(want.repeat_again),
						WORD_W'(repeat_again));
				end
				results_seen++;
			end
			if (!held_off && results_seen >= HOLD_AT) begin
				held_off = 1'b1;
				holdoff_left = HOLD_LEN;
			end
			if (holdoff_left != 0) begin
				holdoff_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		pending_items.push_back(make_item(OP_NEG, 8'h00, 6'h3F, 16'h0000, 16'h0000,
			16'h0000, 8'h00));
		pending_items.push_back(make_item(OP_NEG, 8'h80, 6'h00, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'hFF));
		pending_items.push_back(make_item(OP_NEG, 8'h01, 6'h00, 16'h1234, 16'h5678,
			16'h9ABC, 8'h55));
		pending_items.push_back(make_item(OP_NEG, 8'hFF, 6'h3F, 16'h0001, 16'h0002,
			16'h0003, 8'hAA));
		pending_items.push_back(make_item(OP_NEG, 8'h10, 6'h15, 16'h0000, 16'h0000,
			16'h0000, 8'h00));
		pending_items.push_back(make_item(OP_RRD, 8'hFF, 6'h3F, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'h00));
		pending_items.push_back(make_item(OP_RRD, 8'h00, 6'h00, 16'h0000, 16'h0000,
			16'h0000, 8'h00));
		pending_items.push_back(make_item(OP_RRD, 8'h5A, 6'h01, 16'h0000, 16'h0000,
			16'hBEEF, 8'hC3));
		pending_items.push_back(make_item(OP_RLD, 8'h00, 6'h3E, 16'h0000, 16'h0000,
			16'h0000, 8'hFF));
		pending_items.push_back(make_item(OP_RLD, 8'h87, 6'h01, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'h0F));
		pending_items.push_back(make_item(OP_LDI, 8'h12, 6'h3F, 16'h0001, 16'hFFFF,
			16'hFFFF, 8'hFF));
		pending_items.push_back(make_item(OP_LDI, 8'h00, 6'h00, 16'h0000, 16'h0000,
			16'h0000, 8'h00));
		pending_items.push_back(make_item(OP_LDD, 8'hFF, 6'h3F, 16'h0000, 16'h0000,
			16'h0000, 8'hA5));
		pending_items.push_back(make_item(OP_LDD, 8'h00, 6'h00, 16'h0002, 16'hFFFF,
			16'hFFFF, 8'h5A));
		pending_items.push_back(make_item(OP_CPI, 8'h42, 6'h00, 16'h0001, 16'h0000,
			16'hFFFF, 8'h42));
		pending_items.push_back(make_item(OP_CPI, 8'h42, 6'h3F, 16'h0005, 16'h0000,
			16'h0000, 8'h42));
		pending_items.push_back(make_item(OP_CPI, 8'h00, 6'h01, 16'h0000, 16'hFFFF,
			16'h1000, 8'hFF));
		pending_items.push_back(make_item(OP_CPD, 8'hFF, 6'h3E, 16'hFFFF, 16'h0000,
			16'h0000, 8'h00));
		pending_items.push_back(make_item(OP_CPD, 8'h10, 6'h00, 16'h0001, 16'h0000,
			16'h0000, 8'h01));
		pending_items.push_back(make_item(OP_NOP, 8'hFF, 6'h3F, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'hFF));
		pending_items.push_back(make_item(OP_NOP, 8'h00, 6'h00, 16'h0000, 16'h0000,
			16'h0000, 8'h00));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 81;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 81;
				end
				default: begin
					send_idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_items.push_back(random_item());
			while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
				@(negedge clk);
		end
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		$display("Ran %0d items (%0d results) through four idle/stall mixes,", items_sent,
			results_seen);
		$display("with every operation, the unused code and a long result hold-off.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
